/* src/ps_pkg.sv */
`timescale 1ns / 1ps

package ps_pkg;

   // Fixed widths of the item fields.
   localparam int LIMIT_W = 9;
   localparam int VALUE_W = 9;
   localparam int TOTAL_W = 6;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMPTY,
      ST_CLEAR,
      ST_BASE_RD,
      ST_BASE_CHK,
      ST_MARK,
      ST_CNT_RD,
      ST_CNT_CHK,
      ST_EMIT_RD,
      ST_EMIT_CHK
   } ps_state_type;

endpackage

/* src/ps_if.sv */
`timescale 1ns / 1ps

interface ps_req_if import ps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink (input valid, input limit, output ready);
endinterface

interface ps_rsp_if import ps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] prime_value;
   logic [TOTAL_W-1:0] prime_total;
   logic               last;
   logic               none_found;

   modport source (output valid, output prime_value, output prime_total,
                   output last, output none_found, input ready);
   modport sink (input valid, input prime_value, input prime_total,
                 input last, input none_found, output ready);
endinterface

/* src/prime_sieve.sv */
`timescale 1ns / 1ps

// Sieve of Eratosthenes. Each request item carries an inclusive limit, which
// saturates to MAX_LIMIT. The block answers with one response item per prime
// from 2 up to the limit, in ascending order; every response carries the
// total prime count and the final one has last set. A limit below 2 gives a
// single response with prime_value 0, prime_total 0, last and none_found set.
// The composite bitmap lives in a single-port-write, registered-read memory
// of MAX_LIMIT+1 one-bit entries. One item takes one pass per phase over that
// memory: the request is accepted, entries 0 to lim are cleared, each sieve
// base from 2 is read and checked up to and including the first base whose
// square passes lim, each base found unmarked marks its multiples from its
// square up to lim, entries 2 to lim are read to count the primes, and they
// are read again to emit them, each prime waiting while the response side
// stalls. The memory port is the bottleneck of every phase.
// A new request is taken only once the previous item's last response has
// been loaded into the output register; that response may still be waiting
// on the sink when the next request is accepted.

module prime_sieve import ps_pkg::*; #(
   parameter int MAX_LIMIT = 256
) (
   input  logic      clock,
   input  logic      reset,
   ps_req_if.sink    req_ch,
   ps_rsp_if.source  rsp_ch
);

   // Address width covers entries 0 to MAX_LIMIT.
   localparam int AW = $clog2(MAX_LIMIT + 1);
   localparam int PW = 2 * AW;

   // Sequencer state.
   ps_state_type state_ff, state_in;

   // Working registers.
   logic [AW-1:0]      lim_ff, lim_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [AW:0]        mult_ff, mult_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] count_ff, count_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_none_ff, rsp_none_in;

   // Composite bitmap memory.
   logic               comp_mem [0:MAX_LIMIT];
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic               mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic               rd_data_ff;

   // Decoded conditions.
   logic               req_fire;
   logic               slot_free;
   logic [AW-1:0]      lim_sat;
   logic               lim_small;
   logic [PW-1:0]      base_sq;
   logic               sq_over;
   logic               mult_over;
   logic               idx_at_lim;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign lim_sat    = (req_ch.limit > LIMIT_W'(MAX_LIMIT)) ? AW'(MAX_LIMIT)
                                                            : req_ch.limit[AW-1:0];
   assign lim_small  = (lim_sat < AW'(2));
   assign base_sq    = PW'(base_ff) * PW'(base_ff);
   assign sq_over    = (base_sq > PW'(lim_ff));
   assign mult_over  = (mult_ff > (AW+1)'(lim_ff));
   assign idx_at_lim = (idx_ff == lim_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = lim_small ? ST_EMPTY : ST_CLEAR;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (idx_at_lim) begin
               state_in = ST_BASE_RD;
            end
         end
         ST_BASE_RD: begin
            state_in = ST_BASE_CHK;
         end
         ST_BASE_CHK: begin
            if (sq_over) begin
               state_in = ST_CNT_RD;
            end else if (rd_data_ff) begin
               state_in = ST_BASE_RD;
            end else begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (mult_over) begin
               state_in = ST_BASE_RD;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            state_in = idx_at_lim ? ST_EMIT_RD : ST_CNT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_CHK;
         end
         ST_EMIT_CHK: begin
            if (rd_data_ff || slot_free) begin
               state_in = idx_at_lim ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory controls and output register loads.
   always_comb begin
      lim_in       = lim_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      mult_in      = mult_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = 1'b0;
      mem_raddr    = idx_ff;
      req_ch.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               lim_in   = lim_sat;
               idx_in   = '0;
               base_in  = AW'(2);
               total_in = '0;
               count_in = '0;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_total_in = '0;
               rsp_last_in  = 1'b1;
               rsp_none_in  = 1'b1;
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = 1'b0;
            idx_in    = idx_ff + AW'(1);
         end
         ST_BASE_RD: begin
            mem_raddr = base_ff;
         end
         ST_BASE_CHK: begin
            mem_raddr = base_ff;
            if (sq_over) begin
               idx_in = AW'(2);
            end else if (rd_data_ff) begin
               base_in = base_ff + AW'(1);
            end else begin
               // Marking starts at the square; smaller multiples are
               // already marked by smaller bases.
               mult_in = base_sq[AW:0];
            end
         end
         ST_MARK: begin
            if (mult_over) begin
               base_in = base_ff + AW'(1);
            end else begin
               mem_we    = 1'b1;
               mem_waddr = mult_ff[AW-1:0];
               mem_wdata = 1'b1;
               mult_in   = mult_ff + (AW+1)'(base_ff);
            end
         end
         ST_CNT_RD: begin
            mem_raddr = idx_ff;
         end
         ST_CNT_CHK: begin
            if (!rd_data_ff) begin
               total_in = total_ff + TOTAL_W'(1);
            end
            idx_in = idx_at_lim ? AW'(2) : idx_ff + AW'(1);
         end
         ST_EMIT_RD: begin
            mem_raddr = idx_ff;
         end
         ST_EMIT_CHK: begin
            // The read address stays put so the read data holds while the
            // output register is still occupied.
            mem_raddr = idx_ff;
            if (!rd_data_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VALUE_W'(idx_ff);
               rsp_total_in = total_ff;
               rsp_last_in  = ((count_ff + TOTAL_W'(1)) == total_ff);
               rsp_none_in  = 1'b0;
               count_in     = count_ff + TOTAL_W'(1);
            end
            if (rd_data_ff || slot_free) begin
               idx_in = idx_ff + AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Bitmap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         comp_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= comp_mem[mem_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      idx_ff       <= idx_in;
      base_ff      <= base_in;
      mult_ff      <= mult_in;
      total_ff     <= total_in;
      count_ff     <= count_in;
      rsp_value_ff <= rsp_value_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_none_ff  <= rsp_none_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.prime_value = rsp_value_ff;
   assign rsp_ch.prime_total = rsp_total_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.none_found  = rsp_none_ff;

endmodule
